@@ src/cobsfd_pkg.sv @@
// Shared types and constants for the COBS frame decoder.
`default_nettype none

package cobsfd_pkg;

    // Width of the configuration port and of the register index
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0]  DELIMITER_RST = 8'd0;
    localparam logic [15:0] MAX_LEN_RST   = 16'd256;

    // Group code that carries no stuffed delimiter; also the saturation point
    localparam logic [7:0] GROUP_FULL = 8'd255;

    // Result kind and status codes
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_END   = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OVF = 1'b1;

    // Framing state carried from byte to byte
    typedef struct packed {
        logic       in_frame;
        logic [7:0] group_pos;
        logic [7:0] group_code;
    } frame_state_t;

    // One result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        kind;
        logic        status;
        logic [15:0] frame_length;
    } result_t;

endpackage

`default_nettype wire

@@ src/cobsfd_step.sv @@
// Per-byte decode logic: next framing state, byte count and result for one byte.
`default_nettype none

module cobsfd_step
    import cobsfd_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic [7:0]            byte_in,
    input  wire frame_state_t          state,
    input  wire logic [COUNT_BITS-1:0] count,
    input  wire logic [7:0]            delimiter,
    input  wire logic [15:0]           max_frame_len,
    output frame_state_t               state_next,
    output logic [COUNT_BITS-1:0]      count_next,
    output logic                       emit,
    output result_t                    result
);

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [CMP_W-1:0]      count_ext;
    logic [CMP_W-1:0]      limit_ext;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CMP_W-1:0]      count_inc_ext;
    logic                  limit_hit;
    logic                  is_delim;
    logic                  group_end;

    assign count_ext     = CMP_W'(count);
    assign limit_ext     = CMP_W'(max_frame_len);
    assign count_inc     = count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    assign count_inc_ext = CMP_W'(count_inc);
    assign limit_hit     = (count_ext >= limit_ext);
    assign is_delim      = (byte_in == delimiter);
    assign group_end     = (state.group_pos == state.group_code);

    // Decide the next state and the result for this byte
    always_comb
    begin
        state_next          = state;
        count_next          = count;
        emit                = 1'b0;
        result.out_byte     = 8'd0;
        result.kind         = KIND_DATA;
        result.status       = STATUS_OK;
        result.frame_length = count_ext[15:0];

        if (!state.in_frame)
        begin
            // Hunt: only the delimiter opens a frame
            if (is_delim)
            begin
                state_next.in_frame   = 1'b1;
                state_next.group_pos  = GROUP_FULL;
                state_next.group_code = GROUP_FULL;
                count_next            = '0;
            end
        end
        else if (limit_hit)
        begin
            // Close the frame on overflow, consuming this byte
            state_next.in_frame = 1'b0;
            emit                = 1'b1;
            result.kind         = KIND_END;
            result.status       = STATUS_OVF;
        end
        else if (is_delim)
        begin
            // Close the frame normally
            state_next.in_frame = 1'b0;
            emit                = 1'b1;
            result.kind         = KIND_END;
        end
        else if (group_end)
        begin
            // Start a new group; emit the stuffed delimiter unless the code was full
            state_next.group_code = byte_in;
            state_next.group_pos  = 8'd1;
            if (state.group_code != GROUP_FULL)
            begin
                count_next          = count_inc;
                emit                = 1'b1;
                result.out_byte     = delimiter;
                result.frame_length = count_inc_ext[15:0];
            end
        end
        else
        begin
            // Pass a data byte on and advance within the group
            count_next          = count_inc;
            emit                = 1'b1;
            result.out_byte     = byte_in;
            result.frame_length = count_inc_ext[15:0];
            if (state.group_pos != GROUP_FULL)
            begin
                state_next.group_pos = state.group_pos + 8'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/cobs_frame_decoder.sv @@
// A request accepted into the input register loads the result register when it
//   advances, and its result is then held on the output channel until it is taken.
// Throughput: one byte per cycle unless a stalled full result register holds it; the
//   only loop is the framing state and byte count, between input and result registers.
// Bytes that give no result still pass through the input register.
// Reset (rst_n low, asynchronous): pipeline empty, hunting for a delimiter,
//   delimiter 0 and frame limit 256.
`default_nettype none

module cobs_frame_decoder
    import cobsfd_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration write port
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // Input channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             byte_in,
    // Output channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [7:0]                  out_byte,
    output logic                        kind,
    output logic                        status,
    output logic [15:0]                 frame_length
);

    logic [7:0]            delimiter_reg;
    logic [15:0]           max_len_reg;

    logic                  s1_valid_reg;
    logic [7:0]            s1_byte_reg;

    frame_state_t          state_reg;
    frame_state_t          state_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    logic                  out_valid_reg;
    result_t               result_reg;
    result_t               result_next;
    logic                  emit;
    logic                  advance;

    // Process the held byte when the result register is free or draining
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DELIMITER_RST;
            max_len_reg   <= MAX_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DELIMITER: delimiter_reg <= cfg_wr_data[7:0];
                CFG_MAX_LEN:   max_len_reg   <= cfg_wr_data[15:0];
                default:       ;
            endcase
        end
    end

    // Hold the input register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Capture the request byte
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= byte_in;
        end
    end

    cobsfd_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .byte_in       (s1_byte_reg),
        .state         (state_reg),
        .count         (count_reg),
        .delimiter     (delimiter_reg),
        .max_frame_len (max_len_reg),
        .state_next    (state_next),
        .count_next    (count_next),
        .emit          (emit),
        .result        (result_next)
    );

    // Advance the framing state and byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.in_frame   <= 1'b0;
            state_reg.group_pos  <= GROUP_FULL;
            state_reg.group_code <= GROUP_FULL;
            count_reg            <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Result register valid flag: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = result_reg.out_byte;
    assign kind         = result_reg.kind;
    assign status       = result_reg.status;
    assign frame_length = result_reg.frame_length;

endmodule

`default_nettype wire

@@ test/tb_cobs_frame_decoder.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the COBS frame decoder: directed frames, then random traffic.

module tb_cobs_frame_decoder
    import cobsfd_pkg::*;
();

    localparam int RANDOM_ITEMS = 1850;
    localparam int PHASE_ITEMS  = 150;
    localparam int DRAIN_CYCLES = 4;

    // Plain frame at reset settings: stuffed delimiters, empty frame, bytes while hunting
    localparam logic [7:0] BASIC_SEQ [11] = '{
        8'h12, 8'h00, 8'h03, 8'hFF, 8'h01, 8'h01, 8'h02, 8'hAA, 8'h00, 8'h00, 8'h00
    };
    // Delimiter FF, limit 3: code byte zero, overflow on the closing delimiter
    localparam logic [7:0] OVERFLOW_SEQ [13] = '{
        8'hFF, 8'h00, 8'h55, 8'h00, 8'h80, 8'hFF, 8'h01,
        8'hFF, 8'h02, 8'h33, 8'h01, 8'h7E, 8'hFF
    };
    // Delimiter FF, limit 0: the first in-frame byte overflows
    localparam logic [7:0] ZERO_LIMIT_SEQ [4] = '{8'hFF, 8'h7E, 8'hFF, 8'hFF};

    // Tracks the decoder's framing state and holds the results it must produce
    class decode_scoreboard;
        localparam int MAX_REPORTS = 10;

        logic [7:0]  delim;
        logic [15:0] max_len;
        bit          in_frame;
        logic [7:0]  group_pos;
        logic [7:0]  group_code;
        logic [15:0] count;
        result_t     expected_q[$];
        int          mismatches;

        function new();
            delim      = DELIMITER_RST;
            max_len    = MAX_LEN_RST;
            in_frame   = 1'b0;
            group_pos  = GROUP_FULL;
            group_code = GROUP_FULL;
            count      = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_DELIMITER)
                delim = value[7:0];
            else
                max_len = value[15:0];
        endfunction

        function void push_result(logic [7:0] b, logic k, logic s);
            result_t r;
            r.out_byte     = b;
            r.kind         = k;
            r.status       = s;
            r.frame_length = count;
            expected_q.push_back(r);
        endfunction

        // Advance the framing state by one request; return 0 for a byte dropped while hunting
        function bit note_byte(logic [7:0] b);
            bit stuffed;
            if (!in_frame)
            begin
                if (b == delim)
                begin
                    in_frame   = 1'b1;
                    group_pos  = GROUP_FULL;
                    group_code = GROUP_FULL;
                    count      = '0;
                end
                return b == delim;
            end
            // Limit check comes first, even for the closing delimiter
            if (count >= max_len)
            begin
                in_frame = 1'b0;
                push_result(8'h00, KIND_END, STATUS_OVF);
                return 1'b1;
            end
            if (b == delim)
            begin
                in_frame = 1'b0;
                push_result(8'h00, KIND_END, STATUS_OK);
                return 1'b1;
            end
            // End of group: take the new code, emit a stuffed delimiter unless the group was full
            if (group_pos == group_code)
            begin
                stuffed    = group_code != GROUP_FULL;
                group_code = b;
                group_pos  = 8'd1;
                if (stuffed)
                begin
                    count++;
                    push_result(delim, KIND_DATA, STATUS_OK);
                end
                return 1'b1;
            end
            count++;
            if (group_pos < GROUP_FULL)
                group_pos++;
            push_result(b, KIND_DATA, STATUS_OK);
            return 1'b1;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected result byte=%02h kind=%0d status=%0d len=%0d",
                             $time, got.out_byte, got.kind, got.status, got.frame_length);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                got.status !== want.status || got.frame_length !== want.frame_length)
            begin
                if (mismatches < MAX_REPORTS)
                begin
                    $display("%0t: mismatch expected byte=%02h kind=%0d status=%0d len=%0d,",
                             $time, want.out_byte, want.kind, want.status, want.frame_length);
                    $display("    got byte=%02h kind=%0d status=%0d len=%0d",
                             got.out_byte, got.kind, got.status, got.frame_length);
                end
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [7:0]             byte_in     = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [7:0]             out_byte;
    logic                   kind;
    logic                   status;
    logic [15:0]            frame_length;

    decode_scoreboard books;
    bit               calm     = 1'b0;
    int               consumed = 0;

    cobs_frame_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_in      (byte_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .kind         (kind),
        .status       (status),
        .frame_length (frame_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length for either side: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Stall the result side at random
    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            n = gap_len();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    end

    // Check every result taken by the output handshake
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            books.check_result(result_t'({out_byte, kind, status, frame_length}));
    end

    // Offer one byte after an optional gap and hold it until accepted
    task automatic send_byte(input logic [7:0] value);
        int n;
        n = gap_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        void'(books.note_byte(value));
        consumed++;
    endtask

    // Hold off requests until every result is in and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (books.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers; junk in the unused upper bits of the delimiter word
    task automatic configure(input logic [7:0] delim_value, input logic [15:0] limit);
        logic [CFG_DATA_W-1:0] word;
        word        = {8'($urandom), delim_value};
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_DELIMITER;
        cfg_wr_data <= word;
        @(posedge clk);
        books.write_reg(CFG_DELIMITER, word);
        cfg_index   <= CFG_MAX_LEN;
        cfg_wr_data <= limit;
        @(posedge clk);
        books.write_reg(CFG_MAX_LEN, limit);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed frames with random content, plus noise and truncated frames
    task automatic run_frames(input int quota);
        logic [7:0] frame_q[$];
        logic [7:0] d;
        logic [7:0] v;
        int         start;
        int         pick;
        int         code;
        int         len;
        start = consumed;
        d     = books.delim;
        while (consumed - start < quota)
        begin
            frame_q.delete();
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
            frame_q.push_back(d);
            repeat ($urandom_range(1, 5))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    code = $urandom_range(1, 8);
                else if (pick < 85)
                    code = $urandom_range(9, 40);
                else if (pick < 93)
                    code = 255;
                else if (pick < 96)
                    code = 0;
                else
                    code = $urandom_range(0, 255);
                // a code equal to the delimiter would close the frame
                if (code == d)
                    code = (d + 1) % 256;
                frame_q.push_back(8'(code));
                len = (code == 0) ? $urandom_range(0, 12) : code - 1;
                repeat (len)
                begin
                    v = 8'($urandom);
                    // keep the payload clear of the delimiter, bar the odd early close
                    if (v == d && $urandom_range(0, 3) != 0)
                        v = d + 8'd1;
                    frame_q.push_back(v);
                end
            end
            // drop the closing delimiter now and then
            if ($urandom_range(0, 19) != 0)
                frame_q.push_back(d);
            foreach (frame_q[i])
                send_byte(frame_q[i]);
        end
    endtask

    initial
    begin
        int          phase;
        int          start;
        int          r;
        logic [7:0]  d;
        logic [15:0] lim;
        books = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames, first at reset settings
        foreach (BASIC_SEQ[i])
            send_byte(BASIC_SEQ[i]);
        settle();
        configure(8'hFF, 16'd3);
        foreach (OVERFLOW_SEQ[i])
            send_byte(OVERFLOW_SEQ[i]);
        settle();
        configure(8'hFF, 16'd0);
        foreach (ZERO_LIMIT_SEQ[i])
            send_byte(ZERO_LIMIT_SEQ[i]);

        // Random phases, extremes of the settings first
        phase = 0;
        start = consumed;
        while (consumed - start < RANDOM_ITEMS)
        begin
            case (phase)
                0:
                begin
                    d   = 8'h00;
                    lim = 16'hFFFF;
                end
                1:
                begin
                    d   = 8'hFF;
                    lim = 16'd1;
                end
                2:
                begin
                    d   = 8'h00;
                    lim = 16'd256;
                end
                default:
                begin
                    r = $urandom_range(0, 9);
                    d = (r < 5) ? 8'h00 : (r < 7) ? 8'hFF : 8'($urandom);
                    r = $urandom_range(0, 9);
                    if (r < 4)
                        lim = 16'($urandom_range(1, 24));
                    else if (r < 7)
                        lim = 16'($urandom_range(25, 300));
                    else if (r < 9)
                        lim = 16'hFFFF;
                    else
                        lim = 16'($urandom_range(1, 65535));
                end
            endcase
            settle();
            configure(d, lim);
            calm = ($urandom_range(0, 3) == 0);
            run_frames(PHASE_ITEMS);
            phase++;
        end

        settle();
        repeat (20) @(posedge clk);
        if (books.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/cobsfd_pkg.sv
src/cobsfd_step.sv
src/cobs_frame_decoder.sv
test/tb_cobs_frame_decoder.sv
